// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the grid wall map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/gwm_pkg.sv =====
// Types, constants and helper functions of the grid wall map block.
package gwm_pkg;

    localparam int X_LAST_DEF = 8;
    localparam int Y_LAST_DEF = 8;
    localparam int WORD_W     = 11;

    // Stored map entry: visited flag above the cell word
    localparam int ENTRY_W    = WORD_W + 1;
    localparam int VIS_POS    = WORD_W;

    typedef logic [WORD_W-1:0] word_t;

    // Cell word layout
    localparam word_t S_BIT      = 11'h001;
    localparam word_t SK_BIT     = 11'h002;
    localparam word_t E_BIT      = 11'h004;
    localparam word_t EK_BIT     = 11'h008;
    localparam word_t N_BIT      = 11'h010;
    localparam word_t NK_BIT     = 11'h020;
    localparam word_t W_BIT      = 11'h040;
    localparam word_t WK_BIT     = 11'h080;
    localparam word_t COLOR_BIT  = 11'h100;
    localparam word_t SHAPE_BITS = 11'h600;
    localparam int    SHAPE_LSB  = 9;

    localparam logic [1:0] SHAPE_NONE = 2'd0;

    // Side order of the walk: west, north, east, south
    localparam logic [1:0] SIDE_WEST  = 2'd0;
    localparam logic [1:0] SIDE_NORTH = 2'd1;
    localparam logic [1:0] SIDE_EAST  = 2'd2;
    localparam logic [1:0] SIDE_SOUTH = 2'd3;

    // Heading codes and the side each one excludes from pushing
    localparam logic [1:0] HEAD_SKIP_SOUTH = 2'd0;
    localparam logic [1:0] HEAD_SKIP_WEST  = 2'd1;
    localparam logic [1:0] HEAD_SKIP_NORTH = 2'd2;
    localparam logic [1:0] HEAD_SKIP_EAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD,
        ST_WR,
        ST_SELF,
        ST_EMIT
    } gwm_state_t;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       rd;
        logic       wr;
        logic       self_wr;
        logic       pop;
        logic [1:0] side;
    } gwm_cmd_t;

    typedef struct packed {
        logic in_grid;
        logic last;
    } gwm_status_t;

    // Heading code that excludes a given side
    function automatic logic [1:0] skip_code(logic [1:0] side);
        logic [1:0] code;
        case (side)
            SIDE_WEST:  code = HEAD_SKIP_WEST;
            SIDE_NORTH: code = HEAD_SKIP_NORTH;
            SIDE_EAST:  code = HEAD_SKIP_EAST;
            SIDE_SOUTH: code = HEAD_SKIP_SOUTH;
            default:    code = HEAD_SKIP_SOUTH;
        endcase
        return code;
    endfunction

    // Update the neighbour word: the side facing the reported cell gets the
    // wall bit set or cleared and its known bit set
    function automatic word_t put_side(word_t w, logic [1:0] side, logic wall);
        word_t wm;
        word_t km;
        word_t v;
        case (side)
            SIDE_WEST:  begin wm = E_BIT; km = EK_BIT; end
            SIDE_NORTH: begin wm = S_BIT; km = SK_BIT; end
            SIDE_EAST:  begin wm = W_BIT; km = WK_BIT; end
            SIDE_SOUTH: begin wm = N_BIT; km = NK_BIT; end
            default:    begin wm = N_BIT; km = NK_BIT; end
        endcase
        v = wall ? (w | wm) : (w & ~wm);
        return v | km;
    endfunction

endpackage

// ===== hdl/grid_wall_map_frontier_update.sv =====
// Top level of the grid wall map frontier update block.
// Usage:
//   Input channel (in_valid/in_ready) takes one cell report: coordinates,
//   four wall bits, treasure shape and color, heading. Output channel
//   (out_valid/out_ready) gives one result per frontier push in the order
//   west, north, east, south, or a single result with push_valid low when
//   nothing is pushed; last marks the final result of a report.
// Timing:
//   A report inside the grid goes through its transfer, a setup state, a
//   read and a write of the map RAM for each of the four neighbours, where
//   each push is decided, and the write of the cell itself, and then gives
//   its results, one per result transfer. A report outside the grid goes
//   from the setup state straight to its result. The single-port-pair map
//   RAM sets this sequence; one item is in work at a time.
// Reset:
//   rst_n clears both maps (through per-entry flags) and the controller.
// Stall:
//   While out_ready is low the current result holds and no new report is
//   taken.
module grid_wall_map_frontier_update #(
    parameter int X_LAST = gwm_pkg::X_LAST_DEF,
    parameter int Y_LAST = gwm_pkg::Y_LAST_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cell_x,
    input  logic [3:0]  cell_y,
    input  logic        wall_west,
    input  logic        wall_north,
    input  logic        wall_east,
    input  logic        wall_south,
    input  logic [1:0]  treasure_shape,
    input  logic        treasure_color,
    input  logic [1:0]  heading,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cell_word,
    output logic        push_valid,
    output logic [3:0]  push_x,
    output logic [3:0]  push_y,
    output logic        last
);

    import gwm_pkg::*;

    gwm_cmd_t    cmd;
    gwm_status_t status;

    // Sequence the work of one item
    gwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the item, the maps and the result fields
    gwm_datapath #(
        .X_LAST (X_LAST),
        .Y_LAST (Y_LAST)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .wall_west      (wall_west),
        .wall_north     (wall_north),
        .wall_east      (wall_east),
        .wall_south     (wall_south),
        .treasure_shape (treasure_shape),
        .treasure_color (treasure_color),
        .heading        (heading),
        .cell_word      (cell_word),
        .push_valid     (push_valid),
        .push_x         (push_x),
        .push_y         (push_y),
        .last           (last)
    );

endmodule

// ===== hdl/gwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gwm_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 81,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/gwm_ctrl.sv =====
// Controller state machine of the grid wall map block.
`include "assert_macros.svh"

module gwm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gwm_pkg::gwm_status_t status,
    output gwm_pkg::gwm_cmd_t   cmd
);

    import gwm_pkg::*;

    gwm_state_t state_reg, state_next;
    logic [1:0] side_reg, side_next;

    // Hold state and side counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= SIDE_WEST;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    // Sequence one item: evaluate, walk four neighbours and write own cell if in grid, emit
    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.side    = side_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                side_next = SIDE_WEST;
                state_next = status.in_grid ? ST_RD : ST_EMIT;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr = 1'b1;
                if (side_reg == SIDE_SOUTH)
                begin
                    state_next = ST_SELF;
                end
                else
                begin
                    side_next  = side_reg + 2'd1;
                    state_next = ST_RD;
                end
            end
            ST_SELF:
            begin
                cmd.self_wr = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
    `ASSERT_NEXT(a_walk_ends, state_reg == ST_WR && side_reg == SIDE_SOUTH, state_reg == ST_SELF)

endmodule

// ===== hdl/gwm_datapath.sv =====
// Datapath of the grid wall map block: item registers, maps and result mux.
`include "assert_macros.svh"

module gwm_datapath #(
    parameter int X_LAST = gwm_pkg::X_LAST_DEF,
    parameter int Y_LAST = gwm_pkg::Y_LAST_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gwm_pkg::gwm_cmd_t    cmd,
    output gwm_pkg::gwm_status_t status,
    input  logic [3:0]           cell_x,
    input  logic [3:0]           cell_y,
    input  logic                 wall_west,
    input  logic                 wall_north,
    input  logic                 wall_east,
    input  logic                 wall_south,
    input  logic [1:0]           treasure_shape,
    input  logic                 treasure_color,
    input  logic [1:0]           heading,
    output logic [10:0]          cell_word,
    output logic                 push_valid,
    output logic [3:0]           push_x,
    output logic [3:0]           push_y,
    output logic                 last
);

    import gwm_pkg::*;

    localparam int CELLS = (X_LAST + 1) * (Y_LAST + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int XB    = $clog2(X_LAST + 1);
    localparam int YB    = $clog2(Y_LAST + 1);
    localparam int CW0   = (XB > 4) ? XB : 4;
    localparam int CW    = (YB > CW0) ? YB : CW0;

    logic [CW-1:0]    x_reg, y_reg;
    logic [3:0]       walls_reg;
    logic [1:0]       heading_reg;
    word_t            word_reg;
    logic [3:0]       ok_reg;
    logic             in_grid_reg;
    logic [3:0]       mask_reg;
    logic [CELLS-1:0] known_reg;

    logic [CW-1:0]      nx [4];
    logic [CW-1:0]      ny [4];
    logic [AW-1:0]      n_idx [4];
    logic [AW-1:0]      self_idx;
    logic [AW-1:0]      side_idx;
    word_t              word_in;
    logic [ENTRY_W-1:0] ram_rdata;
    word_t              rd_word;
    logic               rd_visited;
    logic               self_visited;
    logic               push_now;
    logic               self_rd;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [1:0]         sel;
    logic               in_grid_in;

    // Build the word of the reported cell from the input fields
    always_comb
    begin
        word_in = SK_BIT | EK_BIT | NK_BIT | WK_BIT;
        if (wall_south) word_in = word_in | S_BIT;
        if (wall_east)  word_in = word_in | E_BIT;
        if (wall_north) word_in = word_in | N_BIT;
        if (wall_west)  word_in = word_in | W_BIT;
        if (treasure_shape != SHAPE_NONE)
        begin
            word_in = word_in | (word_t'(treasure_shape) << SHAPE_LSB) & SHAPE_BITS;
            if (treasure_color) word_in = word_in | COLOR_BIT;
        end
    end

    assign in_grid_in = (int'(cell_x) <= X_LAST) && (int'(cell_y) <= Y_LAST);

    // Latch the item at transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= CW'(cell_x);
            y_reg       <= CW'(cell_y);
            walls_reg   <= {wall_south, wall_east, wall_north, wall_west};
            heading_reg <= heading;
            word_reg    <= word_in;
            in_grid_reg <= in_grid_in;
            ok_reg[SIDE_WEST]  <= in_grid_in && (cell_x != 4'd0);
            ok_reg[SIDE_NORTH] <= in_grid_in && (cell_y != 4'd0);
            ok_reg[SIDE_EAST]  <= in_grid_in && (int'(cell_x) < X_LAST);
            ok_reg[SIDE_SOUTH] <= in_grid_in && (int'(cell_y) < Y_LAST);
        end
    end

    // Neighbour coordinates and map indices
    always_comb
    begin
        nx[SIDE_WEST]  = x_reg - CW'(1);
        ny[SIDE_WEST]  = y_reg;
        nx[SIDE_NORTH] = x_reg;
        ny[SIDE_NORTH] = y_reg - CW'(1);
        nx[SIDE_EAST]  = x_reg + CW'(1);
        ny[SIDE_EAST]  = y_reg;
        nx[SIDE_SOUTH] = x_reg;
        ny[SIDE_SOUTH] = y_reg + CW'(1);
        for (int k = 0; k < 4; k++)
        begin
            n_idx[k] = AW'(int'(nx[k]) * (Y_LAST + 1) + int'(ny[k]));
        end
        self_idx = AW'(int'(x_reg) * (Y_LAST + 1) + int'(y_reg));
        side_idx = n_idx[cmd.side];
    end

    // Read data of unwritten entries counts as zero
    assign rd_word      = known_reg[side_idx] ? ram_rdata[WORD_W-1:0] : '0;
    assign rd_visited   = known_reg[side_idx] && ram_rdata[VIS_POS];
    assign self_visited = known_reg[self_idx] && ram_rdata[VIS_POS];

    // Decide the push of the current side: open, in grid, unvisited, not skipped
    assign push_now = cmd.wr && ok_reg[cmd.side] && !walls_reg[cmd.side] && !rd_visited
                      && (heading_reg != skip_code(cmd.side));

    // Hold pending pushes; drop the oldest at each result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cmd.eval)
        begin
            mask_reg <= '0;
        end
        else if (push_now)
        begin
            mask_reg[cmd.side] <= 1'b1;
        end
        else if (cmd.pop)
        begin
            mask_reg <= mask_reg & (mask_reg - 4'd1);
        end
    end

    // Track which map entries were written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
        end
        else if (cmd.wr && ok_reg[cmd.side])
        begin
            known_reg[side_idx] <= 1'b1;
        end
        else if (cmd.self_wr)
        begin
            known_reg[self_idx] <= 1'b1;
        end
    end

    // Read the neighbour entry, or the own entry during the last neighbour write
    assign self_rd   = cmd.wr && (cmd.side == SIDE_SOUTH);
    assign ram_re    = (cmd.rd && ok_reg[cmd.side]) || self_rd;
    assign ram_raddr = self_rd ? self_idx : side_idx;

    // Write back the neighbour with its mirrored wall and visited mark, then
    // the reported cell's word with its own visited flag kept
    assign ram_we    = (cmd.wr && ok_reg[cmd.side]) || cmd.self_wr;
    assign ram_waddr = cmd.self_wr ? self_idx : side_idx;
    assign ram_wdata = cmd.self_wr ? {self_visited, word_reg}
                                   : {rd_visited | push_now,
                                      put_side(rd_word, cmd.side, walls_reg[cmd.side])};

    gwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_wall_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pick the oldest pending push for the result
    always_comb
    begin
        sel = SIDE_WEST;
        for (int k = 3; k >= 0; k--)
        begin
            if (mask_reg[k]) sel = 2'(k);
        end
    end

    assign cell_word  = word_reg;
    assign push_valid = |mask_reg;
    assign push_x     = push_valid ? nx[sel][3:0] : 4'd0;
    assign push_y     = push_valid ? ny[sel][3:0] : 4'd0;
    assign last       = (mask_reg & (mask_reg - 4'd1)) == 4'd0;

    assign status.in_grid = in_grid_reg;
    assign status.last    = last;

    `ASSERT_NEXT(a_last_drains, cmd.pop && status.last, mask_reg == 4'd0)
    `ASSERT_IMPL(a_wr_in_walk, ram_we, cmd.wr || cmd.self_wr)
    `ASSERT_IMPL(a_push_known, cmd.pop && push_valid, known_reg[n_idx[sel]])

endmodule

// ===== sim/gwm_frontier_checker.sv =====
// Checker that predicts and compares the result stream of the grid wall map block.
`timescale 1ns / 1ps

module gwm_frontier_checker #(
    parameter int X_LAST = gwm_pkg::X_LAST_DEF,
    parameter int Y_LAST = gwm_pkg::Y_LAST_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  cell_x,
    input  logic [3:0]  cell_y,
    input  logic        wall_west,
    input  logic        wall_north,
    input  logic        wall_east,
    input  logic        wall_south,
    input  logic [1:0]  treasure_shape,
    input  logic        treasure_color,
    input  logic [1:0]  heading,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [10:0] cell_word,
    input  logic        push_valid,
    input  logic [3:0]  push_x,
    input  logic [3:0]  push_y,
    input  logic        last,
    output int          fail_count,
    output int          outstanding
);

    import gwm_pkg::*;

    localparam int CELLS = (X_LAST + 1) * (Y_LAST + 1);

    typedef struct packed {
        word_t      word;
        logic       push;
        logic [3:0] px;
        logic [3:0] py;
        logic       last;
    } cell_result_t;

    cell_result_t cell_results_q[$];
    cell_result_t oldest;
    word_t        wall_mem[CELLS];
    logic         visited_mem[CELLS];

    // Flag one field that differs from the prediction
    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Update both maps for the report on the input ports and queue its results
    task automatic predict_report();
        word_t        word;
        cell_result_t res;
        int           nx;
        int           ny;
        int           idx;
        int           pushes;
        logic         has;
        logic         wall;
        logic [1:0]   skip;
        word_t        wm;
        word_t        km;

        word = SK_BIT | EK_BIT | NK_BIT | WK_BIT;
        if (wall_south) word |= S_BIT;
        if (wall_east)  word |= E_BIT;
        if (wall_north) word |= N_BIT;
        if (wall_west)  word |= W_BIT;
        if (treasure_shape != SHAPE_NONE)
            word |= (word_t'(treasure_shape) << SHAPE_LSB) | (treasure_color ? COLOR_BIT : '0);

        pushes = 0;
        res = '0;
        res.word = word;

        if (cell_x <= X_LAST && cell_y <= Y_LAST) begin
            // Walk the sides west, north, east, south
            for (int s = 0; s < 4; s++) begin
                case (s)
                    SIDE_WEST:
                    begin
                        has = cell_x > 0;
                        nx = int'(cell_x) - 1;
                        ny = int'(cell_y);
                        wall = wall_west;
                        skip = HEAD_SKIP_WEST;
                        wm = E_BIT;
                        km = EK_BIT;
                    end
                    SIDE_NORTH:
                    begin
                        has = cell_y > 0;
                        nx = int'(cell_x);
                        ny = int'(cell_y) - 1;
                        wall = wall_north;
                        skip = HEAD_SKIP_NORTH;
                        wm = S_BIT;
                        km = SK_BIT;
                    end
                    SIDE_EAST:
                    begin
                        has = cell_x < X_LAST;
                        nx = int'(cell_x) + 1;
                        ny = int'(cell_y);
                        wall = wall_east;
                        skip = HEAD_SKIP_EAST;
                        wm = W_BIT;
                        km = WK_BIT;
                    end
                    default:
                    begin
                        has = cell_y < Y_LAST;
                        nx = int'(cell_x);
                        ny = int'(cell_y) + 1;
                        wall = wall_south;
                        skip = HEAD_SKIP_SOUTH;
                        wm = N_BIT;
                        km = NK_BIT;
                    end
                endcase

                if (has) begin
                    // Mirror the wall into the neighbour, mark that side known
                    idx = nx * (Y_LAST + 1) + ny;
                    wall_mem[idx] = wall ? (wall_mem[idx] | wm) : (wall_mem[idx] & ~wm);
                    wall_mem[idx] |= km;
                    // Push an open, unvisited neighbour unless the heading skips it
                    if (!wall && !visited_mem[idx] && heading != skip) begin
                        visited_mem[idx] = 1'b1;
                        res.push = 1'b1;
                        res.px = nx[3:0];
                        res.py = ny[3:0];
                        res.last = 1'b0;
                        cell_results_q.push_back(res);
                        pushes++;
                    end
                end
            end
            wall_mem[int'(cell_x) * (Y_LAST + 1) + int'(cell_y)] = word;
        end

        // Close the report: a lone no-push result, or mark the final push
        if (pushes == 0) begin
            res.push = 1'b0;
            res.px = '0;
            res.py = '0;
            res.last = 1'b1;
            cell_results_q.push_back(res);
        end
        else begin
            res = cell_results_q.pop_back();
            res.last = 1'b1;
            cell_results_q.push_back(res);
        end
    endtask

    // Compare result transfers first, then predict any accepted report
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cell_results_q.delete();
            foreach (wall_mem[i]) begin
                wall_mem[i] = '0;
                visited_mem[i] = 1'b0;
            end
            outstanding = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (cell_results_q.size() == 0) begin
                    $error("result transfer with nothing pending: cell_word %0h", cell_word);
                    fail_count++;
                end
                else begin
                    oldest = cell_results_q.pop_front();
                    check_field("cell_word", oldest.word, cell_word);
                    check_field("push_valid", 11'(oldest.push), 11'(push_valid));
                    check_field("push_x", 11'(oldest.px), 11'(push_x));
                    check_field("push_y", 11'(oldest.py), 11'(push_y));
                    check_field("last", 11'(oldest.last), 11'(last));
                end
            end
            if (in_valid && in_ready)
                predict_report();
            outstanding = cell_results_q.size();
        end
    end

endmodule

// ===== sim/grid_wall_map_frontier_update_tb.sv =====
// Testbench top: stimulus, clocking and verdict for the grid wall map frontier update block.
`timescale 1ns / 1ps

module grid_wall_map_frontier_update_tb;
    import gwm_pkg::*;

    localparam int X_LAST         = X_LAST_DEF;
    localparam int Y_LAST         = Y_LAST_DEF;
    localparam int RANDOM_REPORTS = 330;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 30;

    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [1:0] SHAPE_CIRCLE   = 2'd3;

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic       ww;
        logic       wn;
        logic       we;
        logic       ws;
        logic [1:0] shape;
        logic       color;
        logic [1:0] head;
    } cell_report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic        wall_west;
    logic        wall_north;
    logic        wall_east;
    logic        wall_south;
    logic [1:0]  treasure_shape;
    logic        treasure_color;
    logic [1:0]  heading;
    logic        out_valid;
    logic        out_ready;
    logic [10:0] cell_word;
    logic        push_valid;
    logic [3:0]  push_x;
    logic [3:0]  push_y;
    logic        last;

    int           fail_count;
    int           outstanding;
    int           cycle_count;
    logic         steady;
    cell_report_t rep;
    cell_report_t directed_q[$];

    grid_wall_map_frontier_update #(
        .X_LAST(X_LAST),
        .Y_LAST(Y_LAST)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cell_x(cell_x),
        .cell_y(cell_y),
        .wall_west(wall_west),
        .wall_north(wall_north),
        .wall_east(wall_east),
        .wall_south(wall_south),
        .treasure_shape(treasure_shape),
        .treasure_color(treasure_color),
        .heading(heading),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cell_word(cell_word),
        .push_valid(push_valid),
        .push_x(push_x),
        .push_y(push_y),
        .last(last)
    );

    gwm_frontier_checker #(
        .X_LAST(X_LAST),
        .Y_LAST(Y_LAST)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cell_x(cell_x),
        .cell_y(cell_y),
        .wall_west(wall_west),
        .wall_north(wall_north),
        .wall_east(wall_east),
        .wall_south(wall_south),
        .treasure_shape(treasure_shape),
        .treasure_color(treasure_color),
        .heading(heading),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cell_word(cell_word),
        .push_valid(push_valid),
        .push_x(push_x),
        .push_y(push_y),
        .last(last),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stall the result side at random, except in the steady stretch
    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 33);
    end

    function automatic cell_report_t make_report(input int x, input int y,
                                                 input bit ww, input bit wn,
                                                 input bit we, input bit ws,
                                                 input logic [1:0] shape,
                                                 input logic color,
                                                 input logic [1:0] head);
        cell_report_t r;
        r.x = x[3:0];
        r.y = y[3:0];
        r.ww = ww;
        r.wn = wn;
        r.we = we;
        r.ws = ws;
        r.shape = shape;
        r.color = color;
        r.head = head;
        return r;
    endfunction

    // Idle at random, then hold the report until its transfer
    task automatic send_report(input cell_report_t r);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        cell_x         <= r.x;
        cell_y         <= r.y;
        wall_west      <= r.ww;
        wall_north     <= r.wn;
        wall_east      <= r.we;
        wall_south     <= r.ws;
        treasure_shape <= r.shape;
        treasure_color <= r.color;
        heading        <= r.head;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial begin
        rst_n          = 1'b0;
        steady         = 1'b0;
        out_ready      = 1'b0;
        in_valid       = 1'b0;
        cell_x         = '0;
        cell_y         = '0;
        wall_west      = 1'b0;
        wall_north     = 1'b0;
        wall_east      = 1'b0;
        wall_south     = 1'b0;
        treasure_shape = SHAPE_NONE;
        treasure_color = 1'b0;
        heading        = HEAD_SKIP_SOUTH;

        // Open cells with each heading; no shape but color set clears treasure
        directed_q.push_back(make_report(4, 4, 0, 0, 0, 0, SHAPE_NONE, 1, HEAD_SKIP_SOUTH));
        directed_q.push_back(make_report(2, 2, 0, 0, 0, 0, SHAPE_SQUARE, 0, HEAD_SKIP_WEST));
        directed_q.push_back(make_report(6, 2, 0, 0, 0, 0, SHAPE_TRIANGLE, 1, HEAD_SKIP_NORTH));
        directed_q.push_back(make_report(2, 6, 0, 0, 0, 0, SHAPE_CIRCLE, 1, HEAD_SKIP_EAST));
        // Boxed-in cell, no push
        directed_q.push_back(make_report(6, 6, 1, 1, 1, 1, SHAPE_CIRCLE, 0, HEAD_SKIP_SOUTH));
        // Corners and edges of the grid
        directed_q.push_back(make_report(0, 0, 0, 0, 0, 0, SHAPE_SQUARE, 1, HEAD_SKIP_WEST));
        directed_q.push_back(make_report(X_LAST, Y_LAST, 0, 0, 0, 0, SHAPE_TRIANGLE, 0,
                                         HEAD_SKIP_EAST));
        directed_q.push_back(make_report(0, Y_LAST, 0, 0, 0, 0, SHAPE_NONE, 0,
                                         HEAD_SKIP_NORTH));
        directed_q.push_back(make_report(X_LAST, 0, 0, 0, 0, 0, SHAPE_CIRCLE, 1,
                                         HEAD_SKIP_SOUTH));
        directed_q.push_back(make_report(0, 4, 0, 1, 0, 1, SHAPE_SQUARE, 0, HEAD_SKIP_EAST));
        directed_q.push_back(make_report(4, 0, 1, 0, 1, 0, SHAPE_TRIANGLE, 1, HEAD_SKIP_WEST));
        // Cells outside the grid leave both maps alone
        directed_q.push_back(make_report(15, 15, 0, 0, 0, 0, SHAPE_TRIANGLE, 1,
                                         HEAD_SKIP_NORTH));
        directed_q.push_back(make_report(X_LAST + 1, 4, 1, 0, 1, 0, SHAPE_CIRCLE, 1,
                                         HEAD_SKIP_EAST));
        directed_q.push_back(make_report(4, Y_LAST + 1, 0, 1, 0, 1, SHAPE_NONE, 0,
                                         HEAD_SKIP_WEST));
        directed_q.push_back(make_report(15, 0, 1, 1, 1, 1, SHAPE_SQUARE, 1, HEAD_SKIP_SOUTH));
        // Revisit: neighbours already visited, walls overwrite mirrored sides
        directed_q.push_back(make_report(4, 4, 0, 0, 0, 0, SHAPE_SQUARE, 0, HEAD_SKIP_NORTH));
        directed_q.push_back(make_report(4, 5, 1, 0, 1, 0, SHAPE_CIRCLE, 1, HEAD_SKIP_SOUTH));
        directed_q.push_back(make_report(1, 1, 0, 1, 0, 1, SHAPE_TRIANGLE, 0, HEAD_SKIP_NORTH));
        directed_q.push_back(make_report(7, 7, 1, 1, 0, 0, SHAPE_NONE, 1, HEAD_SKIP_WEST));
        directed_q.push_back(make_report(3, 7, 0, 0, 1, 1, SHAPE_SQUARE, 1, HEAD_SKIP_EAST));

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_q[i])
            send_report(directed_q[i]);

        // Random reports: mostly inside the grid, some outside, walls biased open
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            steady = (n >= 120 && n < 200);
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1) == 0) begin
                    rep.x = 4'($urandom_range(15, X_LAST + 1));
                    rep.y = 4'($urandom_range(15));
                end
                else begin
                    rep.x = 4'($urandom_range(15));
                    rep.y = 4'($urandom_range(15, Y_LAST + 1));
                end
            end
            else begin
                rep.x = 4'($urandom_range(X_LAST));
                rep.y = 4'($urandom_range(Y_LAST));
            end
            rep.ww    = ($urandom_range(99) < 40);
            rep.wn    = ($urandom_range(99) < 40);
            rep.we    = ($urandom_range(99) < 40);
            rep.ws    = ($urandom_range(99) < 40);
            rep.shape = 2'($urandom_range(3));
            rep.color = 1'($urandom_range(1));
            rep.head  = 2'($urandom_range(3));
            send_report(rep);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        steady = 1'b0;

        // Drain remaining results, then watch for stray transfers
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gwm_pkg.sv
hdl/gwm_ram.sv
hdl/gwm_ctrl.sv
hdl/gwm_datapath.sv
hdl/grid_wall_map_frontier_update.sv
sim/gwm_frontier_checker.sv
sim/grid_wall_map_frontier_update_tb.sv
